>>> rtl/ulbp_pkg.sv
// Shared types, constants and the uniform-bin mapping for the uniform LBP code map.
// Used by ulbp_pos, ulbp_core, the top level and the testbench; depends on nothing.
package ulbp_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W      = 8;
	localparam int BIN_W      = 6;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 12;
	localparam int COL_W      = ADDR_W;
	localparam int LINE_W     = 2 * PIX_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = HEIGHT_W;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(48);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(48);
	localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(MAX_HEIGHT);

	localparam logic [BIN_W-1:0] BIN_FLAT   = BIN_W'(56);
	localparam logic [BIN_W-1:0] BIN_NONUNI = BIN_W'(57);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              emit;
		logic              last;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [PIX_W-1:0]  pixel;
	} item_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [LINE_W-1:0] data;
	} ram_wr_t;

	function automatic logic [BIN_W-1:0] uniform_bin(input logic [7:0] code);
		logic [7:0] prev;
		logic [7:0] rise;
		logic [3:0] trans;
		logic [3:0] ones;
		logic [2:0] start;
		prev  = {code[6:0], code[7]};
		rise  = code & ~prev;
		trans = 4'($countones(code ^ prev));
		ones  = 4'($countones(code));
		start = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (rise[i]) start = 3'(i);
		end
		if (code == 8'h00 || code == 8'hff) return BIN_FLAT;
		if (trans != 4'd2) return BIN_NONUNI;
		return BIN_W'(7 * start) + BIN_W'(ones) - BIN_W'(1);
	endfunction

endpackage

>>> rtl/ulbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered,
// enabled read data. Stand-alone; no package dependency.
module ulbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ulbp_pos.sv
// Geometry registers, raster position counters and the input stage register.
// Depends on ulbp_pkg; issues the line-store read for each accepted pixel.
module ulbp_pos (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [ulbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ulbp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic [ulbp_pkg::PIX_W-1:0]          pixel,
	input  logic                                go,
	output logic                                s1_valid,
	output ulbp_pkg::item_t                     item_s1,
	output logic                                rd_en,
	output logic [ulbp_pkg::ADDR_W-1:0]         rd_addr
);

	logic [ulbp_pkg::WIDTH_W-1:0]  width_q;
	logic [ulbp_pkg::HEIGHT_W-1:0] height_q;
	logic [ulbp_pkg::COL_W-1:0]    col_q;
	logic [ulbp_pkg::ROW_W-1:0]    row_q;
	logic [ulbp_pkg::WIDTH_W-1:0]  w_eff;
	logic [ulbp_pkg::HEIGHT_W-1:0] h_eff;
	logic                          col_wrap;
	logic [ulbp_pkg::HEIGHT_W-1:0] row_pre;
	logic [ulbp_pkg::COL_W-1:0]    c;
	logic [ulbp_pkg::ROW_W-1:0]    r;
	logic [ulbp_pkg::WIDTH_W-1:0]  c_inc;
	logic [ulbp_pkg::HEIGHT_W-1:0] r_inc;
	logic                          c_wrap;
	logic [ulbp_pkg::COL_W-1:0]    col_d;
	logic [ulbp_pkg::ROW_W-1:0]    row_d;
	logic                          accept;

	always_comb begin
		if (width_q < ulbp_pkg::WIDTH_MIN) w_eff = ulbp_pkg::WIDTH_MIN;
		else if (width_q > ulbp_pkg::WIDTH_MAX) w_eff = ulbp_pkg::WIDTH_MAX;
		else w_eff = width_q;
		if (height_q < ulbp_pkg::HEIGHT_MIN) h_eff = ulbp_pkg::HEIGHT_MIN;
		else if (height_q > ulbp_pkg::HEIGHT_MAX) h_eff = ulbp_pkg::HEIGHT_MAX;
		else h_eff = height_q;
	end

	always_comb begin
		col_wrap = {1'b0, col_q} >= w_eff;
		c        = col_wrap ? '0 : col_q;
		row_pre  = {1'b0, row_q} + ulbp_pkg::HEIGHT_W'(col_wrap);
		r        = (row_pre >= h_eff) ? '0 : row_pre[ulbp_pkg::ROW_W-1:0];
		c_inc    = {1'b0, c} + ulbp_pkg::WIDTH_W'(1);
		r_inc    = {1'b0, r} + ulbp_pkg::HEIGHT_W'(1);
		c_wrap   = c_inc >= w_eff;
		col_d    = c_wrap ? '0 : c_inc[ulbp_pkg::COL_W-1:0];
		if (!c_wrap) row_d = r;
		else if (r_inc >= h_eff) row_d = '0;
		else row_d = r_inc[ulbp_pkg::ROW_W-1:0];
	end

	assign pixel_stall = s1_valid && !go;
	assign accept      = pixel_valid && !pixel_stall;
	assign rd_en       = accept;
	assign rd_addr     = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ulbp_pkg::WIDTH_RST;
			height_q <= ulbp_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ulbp_pkg::REG_WIDTH:  width_q  <= cfg_data[ulbp_pkg::WIDTH_W-1:0];
				ulbp_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				col_q    <= col_d;
				row_q    <= row_d;
				s1_valid <= 1'b1;
			end else if (go) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.emit  <= (r >= ulbp_pkg::ROW_W'(2)) && (c >= ulbp_pkg::COL_W'(2));
			item_s1.last  <= ({1'b0, r} == h_eff - ulbp_pkg::HEIGHT_W'(1)) &&
				({1'b0, c} == w_eff - ulbp_pkg::WIDTH_W'(1));
			item_s1.row   <= r;
			item_s1.col   <= c;
			item_s1.pixel <= pixel;
		end
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid) else $error("accepted pixel did not reach stage 1");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !go) |=> (s1_valid && $stable(item_s1)))
		else $error("stage 1 item changed while held");
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> ({1'b0, item_s1.col} < w_eff))
		else $error("stage 1 column outside the row");

endmodule

>>> rtl/ulbp_core.sv
// 3x3 window, neighbor compare, uniform-bin lookup and the result register.
// Depends on ulbp_pkg; writes back the two line stores held in one RAM.
module ulbp_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s1_valid,
	input  ulbp_pkg::item_t                     item_s1,
	input  logic [ulbp_pkg::LINE_W-1:0]         rd_data,
	output ulbp_pkg::ram_wr_t                   wr,
	output logic                                go,
	output logic                                bin_valid,
	input  logic                                bin_stall,
	output logic [ulbp_pkg::BIN_W-1:0]          bin,
	output logic [ulbp_pkg::ROW_W-1:0]          centre_row,
	output logic [ulbp_pkg::COL_W-1:0]          centre_col,
	output logic                                frame_last
);

	logic [8:0][ulbp_pkg::PIX_W-1:0] win_q;
	logic [8:0][ulbp_pkg::PIX_W-1:0] win_d;
	logic [ulbp_pkg::PIX_W-1:0]      upper;
	logic [ulbp_pkg::PIX_W-1:0]      middle;
	logic [ulbp_pkg::PIX_W-1:0]      ctr;
	logic [7:0]                      code;
	logic                            advance;

	assign upper   = rd_data[ulbp_pkg::LINE_W-1:ulbp_pkg::PIX_W];
	assign middle  = rd_data[ulbp_pkg::PIX_W-1:0];
	assign go      = !bin_valid || !bin_stall;
	assign advance = go && s1_valid;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_d[k*3]   = win_q[k*3+1];
			win_d[k*3+1] = win_q[k*3+2];
		end
		win_d[2] = upper;
		win_d[5] = middle;
		win_d[8] = item_s1.pixel;
		ctr      = win_d[4];
		code[0]  = win_d[5] > ctr;
		code[1]  = win_d[8] > ctr;
		code[2]  = win_d[7] > ctr;
		code[3]  = win_d[6] > ctr;
		code[4]  = win_d[3] > ctr;
		code[5]  = win_d[0] > ctr;
		code[6]  = win_d[1] > ctr;
		code[7]  = win_d[2] > ctr;
	end

	assign wr.we   = advance;
	assign wr.addr = item_s1.col;
	assign wr.data = {middle, item_s1.pixel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			bin_valid <= 1'b0;
		end else begin
			if (advance) win_q <= win_d;
			if (go) bin_valid <= s1_valid && item_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.emit) begin
			bin        <= ulbp_pkg::uniform_bin(code);
			centre_row <= item_s1.row - ulbp_pkg::ROW_W'(1);
			centre_col <= item_s1.col - ulbp_pkg::COL_W'(1);
			frame_last <= item_s1.last;
		end
	end

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.emit) |=> bin_valid) else $error("interior pixel lost its bin");
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid |-> (bin <= ulbp_pkg::BIN_NONUNI)) else $error("bin out of range");
	a_window_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(bin_valid && bin_stall) |=> $stable(win_q)) else $error("window moved while stalled");

endmodule

>>> rtl/uniform_lbp_code_map_top.sv
// Top level of the uniform LBP code map: position stage, line-store RAM and core.
// Depends on ulbp_pkg, ulbp_ram, ulbp_pos and ulbp_core.
//
// Usage:
//   Pixels enter in raster order, frame after frame, on pixel/pixel_valid; a
//   transfer happens on a clock edge with pixel_valid high and pixel_stall low.
//   For every interior pixel one result leaves on bin/centre_row/centre_col/
//   frame_last with bin_valid; the receiver holds it with bin_stall.
//   frame_last marks the last interior bin of a frame.
//   Geometry is set through cfg_valid/cfg_index/cfg_data (index 0 width,
//   index 1 height); cfg_ready is always high. Write only while idle.
//   Throughput: one pixel per clock while pixel_stall is low. The bin of centre
//   (r,c) follows pixel (r+1,c+1): the transfer edge loads the input stage and
//   the registered line-store read together, then the window compare and bin
//   lookup are loaded into the result register once go allows it.
//   Reset clears counters, window and valid flags and sets width and height to
//   48; line stores are not cleared and need no clearing pass.
//   When the receiver stalls with a result waiting, one more pixel is taken into
//   an empty input stage, then pixel_stall rises until the result is taken.
module uniform_lbp_code_map_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ulbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ulbp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic [ulbp_pkg::PIX_W-1:0]          pixel,
	output logic                                bin_valid,
	input  logic                                bin_stall,
	output logic [ulbp_pkg::BIN_W-1:0]          bin,
	output logic [ulbp_pkg::ROW_W-1:0]          centre_row,
	output logic [ulbp_pkg::COL_W-1:0]          centre_col,
	output logic                                frame_last
);

	logic                              go;
	logic                              s1_valid;
	ulbp_pkg::item_t                   item_s1;
	logic                              rd_en;
	logic [ulbp_pkg::ADDR_W-1:0]       rd_addr;
	logic [ulbp_pkg::LINE_W-1:0]       rd_data;
	ulbp_pkg::ram_wr_t                 wr;

	assign cfg_ready = 1'b1;

	ulbp_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.go          (go),
		.s1_valid    (s1_valid),
		.item_s1     (item_s1),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	ulbp_ram #(
		.WIDTH (ulbp_pkg::LINE_W),
		.DEPTH (ulbp_pkg::MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ulbp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.item_s1    (item_s1),
		.rd_data    (rd_data),
		.wr         (wr),
		.go         (go),
		.bin_valid  (bin_valid),
		.bin_stall  (bin_stall),
		.bin        (bin),
		.centre_row (centre_row),
		.centre_col (centre_col),
		.frame_last (frame_last)
	);

endmodule

>>> sim/testbench.sv
// Self-checking testbench for uniform_lbp_code_map_top: raster pixel streams with a
// predictor of the LBP window, line stores and bin table; depends on ulbp_pkg and the RTL.
// Covers a directed frame, clamped and extreme geometries, mid-frame changes and backpressure.
module testbench;

	localparam int NO_CHECK    = -1;
	localparam int HOLD_CYCLES = 400;
	localparam int DIR_LEN     = 27;
	localparam int RANDOM_ITEMS = 540;
	localparam int RING_TAP [8] = '{5, 8, 7, 6, 3, 0, 1, 2};

	localparam logic [ulbp_pkg::PIX_W-1:0] DIR_PX [DIR_LEN] = '{
		8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,
		8'd255, 8'd0,   8'd255,
		8'd255, 8'd255, 8'd255,
		8'd255, 8'd0,   8'd255,
		8'd255, 8'd255, 8'd255,
		8'd0,   8'd254, 8'd0,
		8'd0,   8'd0,   8'd0
	};
	localparam int DIR_BIN [DIR_LEN] = '{
		NO_CHECK, NO_CHECK, NO_CHECK,
		NO_CHECK, NO_CHECK, NO_CHECK,
		NO_CHECK, NO_CHECK, int'(ulbp_pkg::BIN_FLAT),
		NO_CHECK, NO_CHECK, int'(ulbp_pkg::BIN_NONUNI),
		NO_CHECK, NO_CHECK, 4,
		NO_CHECK, NO_CHECK, int'(ulbp_pkg::BIN_FLAT),
		NO_CHECK, NO_CHECK, int'(ulbp_pkg::BIN_FLAT),
		NO_CHECK, NO_CHECK, int'(ulbp_pkg::BIN_FLAT),
		NO_CHECK, NO_CHECK, 37
	};

	typedef enum int {
		TEXTURE_NOISE,
		TEXTURE_TWO_LEVEL,
		TEXTURE_BINARY,
		TEXTURE_RAMP
	} texture_t;

	typedef struct {
		logic [ulbp_pkg::BIN_W-1:0] code_bin;
		logic [ulbp_pkg::ROW_W-1:0] row;
		logic [ulbp_pkg::COL_W-1:0] col;
		logic                       last;
	} lbp_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [ulbp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ulbp_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            pixel_valid;
	logic                            pixel_stall;
	logic [ulbp_pkg::PIX_W-1:0]      pixel;
	logic                            bin_valid;
	logic                            bin_stall;
	logic [ulbp_pkg::BIN_W-1:0]      bin;
	logic [ulbp_pkg::ROW_W-1:0]      centre_row;
	logic [ulbp_pkg::COL_W-1:0]      centre_col;
	logic                            frame_last;

	logic [ulbp_pkg::WIDTH_W-1:0]  cfg_width  = ulbp_pkg::WIDTH_RST;
	logic [ulbp_pkg::HEIGHT_W-1:0] cfg_height = ulbp_pkg::HEIGHT_RST;
	logic [ulbp_pkg::PIX_W-1:0]    line_two_up [ulbp_pkg::MAX_WIDTH];
	logic [ulbp_pkg::PIX_W-1:0]    line_one_up [ulbp_pkg::MAX_WIDTH];
	logic [ulbp_pkg::PIX_W-1:0]    nbhd [9];
	int                            next_row = 0;
	int                            next_col = 0;
	lbp_result_t                   bins_pending [$];

	int mismatch_count = 0;
	int bins_checked   = 0;
	int frames_closed  = 0;
	int pixels_sent    = 0;
	int regs_written   = 0;
	int drv_want       = NO_CHECK;
	bit hold_req       = 1'b0;
	bit tx_gappy       = 1'b0;

	uniform_lbp_code_map_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.bin_valid   (bin_valid),
		.bin_stall   (bin_stall),
		.bin         (bin),
		.centre_row  (centre_row),
		.centre_col  (centre_col),
		.frame_last  (frame_last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [ulbp_pkg::BIN_W-1:0] pattern_bin(input logic [7:0] code);
		int runs;
		int first;
		runs = 0;
		first = 0;
		if (code == 8'h00 || code == 8'hff) return ulbp_pkg::BIN_FLAT;
		for (int i = 0; i < 8; i++) begin
			if (code[i] && !code[(i + 7) % 8]) begin
				runs++;
				first = i;
			end
		end
		if (runs != 1) return ulbp_pkg::BIN_NONUNI;
		return ulbp_pkg::BIN_W'(7 * first + $countones(code) - 1);
	endfunction

	task automatic advance_lbp_window(input logic [ulbp_pkg::PIX_W-1:0] px, input int typed);
		int w;
		int h;
		int r;
		int c;
		logic [7:0] code;
		lbp_result_t res;
		w = (cfg_width < ulbp_pkg::WIDTH_MIN) ? int'(ulbp_pkg::WIDTH_MIN) :
			(cfg_width > ulbp_pkg::WIDTH_MAX) ? int'(ulbp_pkg::WIDTH_MAX) : int'(cfg_width);
		h = (cfg_height < ulbp_pkg::HEIGHT_MIN) ? int'(ulbp_pkg::HEIGHT_MIN) :
			(cfg_height > ulbp_pkg::HEIGHT_MAX) ? int'(ulbp_pkg::HEIGHT_MAX) :
			int'(cfg_height);
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (next_row >= h) next_row = 0;
		r = next_row;
		c = next_col;
		for (int k = 0; k < 3; k++) begin
			nbhd[3 * k]     = nbhd[3 * k + 1];
			nbhd[3 * k + 1] = nbhd[3 * k + 2];
		end
		nbhd[2] = line_two_up[c];
		nbhd[5] = line_one_up[c];
		nbhd[8] = px;
		line_two_up[c] = line_one_up[c];
		line_one_up[c] = px;
		if (r >= 2 && c >= 2) begin
			for (int k = 0; k < 8; k++) code[k] = nbhd[RING_TAP[k]] > nbhd[4];
			res.code_bin = (typed == NO_CHECK) ? pattern_bin(code) : ulbp_pkg::BIN_W'(typed);
			res.row      = ulbp_pkg::ROW_W'(r - 1);
			res.col      = ulbp_pkg::COL_W'(c - 1);
			res.last     = (r == h - 1) && (c == w - 1);
			bins_pending.insert(bins_pending.size(), res);
		end
		next_col = c + 1;
		if (next_col >= w) begin
			next_col = 0;
			next_row = r + 1;
			if (next_row >= h) next_row = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 20)
			$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	always @(posedge clk) begin : tracker
		lbp_result_t want;
		if (bin_valid === 1'b1 && bin_stall === 1'b0) begin
			bins_checked++;
			if (frame_last === 1'b1) frames_closed++;
			if (bins_pending.size() == 0) begin
				report_mismatch("bin with nothing pending", int'(bin), NO_CHECK);
			end else begin
				want = bins_pending.pop_front();
				if (bin !== want.code_bin)
					report_mismatch("bin", int'(bin), int'(want.code_bin));
				if (centre_row !== want.row)
					report_mismatch("centre_row", int'(centre_row), int'(want.row));
				if (centre_col !== want.col)
					report_mismatch("centre_col", int'(centre_col), int'(want.col));
				if (frame_last !== want.last)
					report_mismatch("frame_last", int'(frame_last), int'(want.last));
			end
		end
		if (cfg_valid && cfg_ready === 1'b1) begin
			case (ulbp_pkg::reg_idx_t'(cfg_index))
				ulbp_pkg::REG_WIDTH:  cfg_width = cfg_data[ulbp_pkg::WIDTH_W-1:0];
				ulbp_pkg::REG_HEIGHT: cfg_height = cfg_data;
				default: ;
			endcase
		end
		if (pixel_valid && pixel_stall === 1'b0) advance_lbp_window(pixel, drv_want);
	end

	function automatic int idle_span();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	initial begin : receiver
		int stall_left;
		int hold_left;
		int mode_left;
		bit rx_gappy;
		stall_left = 0;
		hold_left = 0;
		mode_left = 0;
		rx_gappy = 1'b0;
		bin_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				rx_gappy = $urandom_range(0, 2) != 0;
				mode_left = $urandom_range(16, 128);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				bin_stall = 1'b1;
			end else begin
				if (stall_left == 0 && rx_gappy && $urandom_range(0, 3) == 0)
					stall_left = idle_span();
				bin_stall = stall_left > 0;
				if (stall_left > 0) stall_left--;
			end
		end
	end

	task automatic send_pixel(input logic [ulbp_pkg::PIX_W-1:0] px, input int want);
		int gap;
		gap = (tx_gappy && $urandom_range(0, 3) == 0) ? idle_span() : 0;
		if (gap > 0) begin
			pixel_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid = 1'b1;
		pixel = px;
		drv_want = want;
		do @(posedge clk); while (pixel_stall !== 1'b0);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic write_reg(input ulbp_pkg::reg_idx_t idx,
			input logic [ulbp_pkg::CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid = 1'b0;
		regs_written++;
	endtask

	// drain all pending bins, then let the pipeline empty
	task automatic settle();
		pixel_valid = 1'b0;
		while (bins_pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [ulbp_pkg::PIX_W-1:0] shade(input texture_t tex,
			input logic [ulbp_pkg::PIX_W-1:0] base, input int k);
		case (tex)
			TEXTURE_TWO_LEVEL: return base + ulbp_pkg::PIX_W'($urandom_range(0, 1));
			TEXTURE_BINARY:    return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
			TEXTURE_RAMP:      return base + ulbp_pkg::PIX_W'(k) +
				ulbp_pkg::PIX_W'($urandom_range(0, 1));
			default:           return ulbp_pkg::PIX_W'($urandom);
		endcase
	endfunction

	task automatic stream_random(input int count);
		texture_t tex;
		logic [ulbp_pkg::PIX_W-1:0] base;
		tex = TEXTURE_NOISE;
		base = '0;
		for (int k = 0; k < count; k++) begin
			if (k % 64 == 0) begin
				tex = texture_t'($urandom_range(0, 3));
				base = ulbp_pkg::PIX_W'($urandom);
				tx_gappy = $urandom_range(0, 2) != 0;
			end
			send_pixel(shade(tex, base, k), NO_CHECK);
		end
	endtask

	// keep the effective width within the columns filled at reset geometry
	function automatic logic [ulbp_pkg::CFG_DATA_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return ulbp_pkg::CFG_DATA_W'($urandom_range(0, 2));
			1:       return ulbp_pkg::CFG_DATA_W'(ulbp_pkg::WIDTH_RST);
			2:       return ulbp_pkg::CFG_DATA_W'(13'h1000 | $urandom_range(3, 12));
			3:       return ulbp_pkg::CFG_DATA_W'($urandom_range(25, 48));
			default: return ulbp_pkg::CFG_DATA_W'($urandom_range(3, 24));
		endcase
	endfunction

	function automatic logic [ulbp_pkg::CFG_DATA_W-1:0] pick_height();
		case ($urandom_range(0, 9))
			0:       return ulbp_pkg::CFG_DATA_W'($urandom_range(0, 2));
			1:       return ulbp_pkg::CFG_DATA_W'(ulbp_pkg::MAX_HEIGHT);
			2:       return ulbp_pkg::CFG_DATA_W'(8191);
			3:       return ulbp_pkg::CFG_DATA_W'($urandom_range(0, 8191));
			default: return ulbp_pkg::CFG_DATA_W'($urandom_range(3, 12));
		endcase
	endfunction

	initial begin : stimulus
		int random_sent;
		int n;
		random_sent = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ulbp_pkg::REG_WIDTH;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry, with a long receiver hold while the rows stream in
		hold_req = 1'b1;
		stream_random(48 * 4);
		settle();

		// height 3 wraps the row counter on the next pixel, so this frame starts at row 0
		write_reg(ulbp_pkg::REG_WIDTH, ulbp_pkg::CFG_DATA_W'(1));
		write_reg(ulbp_pkg::REG_HEIGHT, ulbp_pkg::CFG_DATA_W'(3));
		stream_random(9);
		settle();

		write_reg(ulbp_pkg::REG_HEIGHT, ulbp_pkg::CFG_DATA_W'(9));
		tx_gappy = 1'b1;
		for (int i = 0; i < DIR_LEN; i++) send_pixel(DIR_PX[i], DIR_BIN[i]);
		settle();

		// short bursts; geometry changes land mid-frame
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) != 0) write_reg(ulbp_pkg::REG_WIDTH, pick_width());
			if ($urandom_range(0, 2) != 0) write_reg(ulbp_pkg::REG_HEIGHT, pick_height());
			n = $urandom_range(20, 120);
			stream_random(n);
			random_sent += n;
			settle();
		end
		repeat (20) @(negedge clk);

		if (bins_pending.size() != 0)
			report_mismatch("bins left pending", bins_pending.size(), 0);
		$display("Run covered %0d pixels, %0d bins checked, %0d frames closed, %0d register writes.",
			pixels_sent, bins_checked, frames_closed, regs_written);
		$display("Widths of 3 to 48 columns and heights up to 4096 rows, clamped and mid-frame.");
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#40000000;
		$display("Timeout: pixels or bins stopped moving");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
